[rtl/rbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbp_pkg;

	// fixed widths of the transaction fields and of the register port
	localparam int DATA_W   = 32;
	localparam int LAYOUT_W = 4;
	localparam int IDX_W    = 8;
	localparam int PADDR_W  = 3;

	// the largest table the 8-bit index can address
	localparam int MAX_ENTRIES = 1 << IDX_W;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_TEX   = 2'd1,
		CMD_BUF   = 2'd2,
		CMD_FINAL = 2'd3
	} cmd_t;

	// register select, taken from paddr[2]
	typedef enum logic {
		REG_WRITE_MASK = 1'b0,
		REG_FINAL_DST  = 1'b1
	} reg_sel_t;

endpackage

`default_nettype wire

[rtl/rbp_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbp_table #(
	parameter int W     = 68,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data,
	output logic      [W-1:0]  rd_data
);

	logic [W-1:0]  mem [DEPTH];
	logic [W-1:0]  rd_q;
	logic [AW-1:0] rd_addr_q;
	logic [W-1:0]  fwd_data_q;
	logic [AW-1:0] fwd_addr_q;
	logic          fwd_valid_q;

	// write port, registered read; the array read in the same cycle as a write sees old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			fwd_data_q <= wr_data;
			fwd_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	// latest write to the same entry wins over the array output
	assign rd_data = (fwd_valid_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

[rtl/resource_barrier_planner_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// pipeline: a transaction is captured in stage 1 with its table read at accept, and
// its decision then goes into the output register; throughput: one transaction per
// cycle unless the barrier channel stalls, set by one read and one write of each
// last-use table per cycle, with a write bypass for back-to-back use of one entry
// reset: arst_n clears the handshake state and both registers to zero; the tables
// hold nothing defined until an init, texture or buffer transaction writes an entry
module resource_barrier_planner_core
	import rbp_pkg::*;
#(
	parameter int NUM_RESOURCES = 256,
	parameter int MASK_BITS     = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// apb register port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic      [DATA_W-1:0]   prdata,
	output logic                     pready,

	// request channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          cmd,
	input  wire logic [IDX_W-1:0]    resource_index,
	input  wire logic [LAYOUT_W-1:0] layout,
	input  wire logic [DATA_W-1:0]   stages,
	input  wire logic [DATA_W-1:0]   access_bits,
	input  wire logic                is_write,
	input  wire logic                init_buffer,

	// barrier channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     is_buffer,
	output logic      [IDX_W-1:0]    barrier_index,
	output logic      [LAYOUT_W-1:0] old_layout,
	output logic      [LAYOUT_W-1:0] new_layout,
	output logic      [DATA_W-1:0]   src_stages,
	output logic      [DATA_W-1:0]   src_access,
	output logic      [DATA_W-1:0]   dst_stages,
	output logic      [DATA_W-1:0]   dst_access
);

	// masks are cut to MASK_BITS and then to the 32-bit field width
	localparam int MW    = (MASK_BITS < DATA_W) ? MASK_BITS : DATA_W;
	// entries beyond the 8-bit index are never reachable
	localparam int DEPTH = (NUM_RESOURCES < MAX_ENTRIES) ? NUM_RESOURCES : MAX_ENTRIES;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic [LAYOUT_W-1:0] layout;
		logic [MW-1:0]       stg;
		logic [MW-1:0]       acc;
	} tex_rec_t;

	typedef struct packed {
		logic [MW-1:0] stg;
		logic [MW-1:0] acc;
	} buf_rec_t;

	localparam int TEX_W = $bits(tex_rec_t);
	localparam int BUF_W = $bits(buf_rec_t);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [MW-1:0] write_mask_q;
	logic [MW-1:0] final_dst_q;
	logic          cfg_wr;
	reg_sel_t      cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_mask_q <= '0;
			final_dst_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_WRITE_MASK: write_mask_q <= pwdata[MW-1:0];
				REG_FINAL_DST:  final_dst_q  <= pwdata[MW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_WRITE_MASK: prdata = DATA_W'(write_mask_q);
			REG_FINAL_DST:  prdata = DATA_W'(final_dst_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// stage 1: captured request plus the table entries read at accept
	// ------------------------------------------------------------------
	logic                in_fire;
	logic                s1_adv;
	logic                valid_s1;
	logic                range_s1;
	cmd_t                cmd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [LAYOUT_W-1:0] layout_s1;
	logic [MW-1:0]       stg_s1;
	logic [MW-1:0]       acc_s1;
	logic                wr_s1;
	logic                ibuf_s1;
	logic                in_range;

	// stage 1 moves on whenever the output register is free or being drained
	assign s1_adv   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;
	assign in_range = (32'(resource_index) < NUM_RESOURCES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			range_s1  <= in_range;
			cmd_s1    <= cmd_t'(cmd);
			idx_s1    <= resource_index;
			layout_s1 <= layout;
			stg_s1    <= stages[MW-1:0];
			acc_s1    <= access_bits[MW-1:0];
			wr_s1     <= is_write;
			ibuf_s1   <= init_buffer;
		end
	end

	// ------------------------------------------------------------------
	// last-use tables
	// ------------------------------------------------------------------
	tex_rec_t tex_rd;
	tex_rec_t tex_wr;
	buf_rec_t buf_rd;
	buf_rec_t buf_wr;
	logic     tex_we;
	logic     buf_we;

	assign tex_wr = '{layout: layout_s1, stg: stg_s1, acc: acc_s1};
	assign buf_wr = '{stg: stg_s1, acc: acc_s1};

	rbp_table #(
		.W     (TEX_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_tex_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (resource_index[AW-1:0]),
		.wr_en   (tex_we),
		.wr_addr (idx_s1[AW-1:0]),
		.wr_data (tex_wr),
		.rd_data (tex_rd)
	);

	rbp_table #(
		.W     (BUF_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_buf_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (resource_index[AW-1:0]),
		.wr_en   (buf_we),
		.wr_addr (idx_s1[AW-1:0]),
		.wr_data (buf_wr),
		.rd_data (buf_rd)
	);

	// ------------------------------------------------------------------
	// hazard decision and table update
	// ------------------------------------------------------------------
	logic tex_hazard;
	logic buf_hazard;
	logic layout_diff;
	logic hit;
	logic tex_upd;
	logic buf_upd;

	assign layout_diff = (tex_rd.layout != layout_s1);
	// a layout change, a stored write or a new write orders the two uses
	assign tex_hazard  = layout_diff || (|(tex_rd.acc & write_mask_q)) || wr_s1;
	assign buf_hazard  = (|(buf_rd.acc & write_mask_q)) || wr_s1;

	always_comb begin
		unique case (cmd_s1)
			CMD_INIT: begin
				hit     = 1'b0;
				tex_upd = !ibuf_s1;
				buf_upd = ibuf_s1;
			end
			CMD_TEX: begin
				hit     = tex_hazard;
				tex_upd = 1'b1;
				buf_upd = 1'b0;
			end
			CMD_BUF: begin
				hit     = buf_hazard;
				tex_upd = 1'b0;
				buf_upd = 1'b1;
			end
			CMD_FINAL: begin
				// final transition only reads the texture record
				hit     = layout_diff;
				tex_upd = 1'b0;
				buf_upd = 1'b0;
			end
			default: begin
				hit     = 1'b0;
				tex_upd = 1'b0;
				buf_upd = 1'b0;
			end
		endcase
	end

	// out-of-range indexes leave the tables alone and give no barrier
	assign tex_we = s1_adv && range_s1 && tex_upd;
	assign buf_we = s1_adv && range_s1 && buf_upd;

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= range_s1 && hit;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && range_s1 && hit) begin
			barrier_index <= idx_s1;
			if (cmd_s1 == CMD_BUF) begin
				is_buffer  <= 1'b1;
				old_layout <= '0;
				new_layout <= '0;
				src_stages <= DATA_W'(buf_rd.stg);
				src_access <= DATA_W'(buf_rd.acc);
			end else begin
				is_buffer  <= 1'b0;
				old_layout <= tex_rd.layout;
				new_layout <= layout_s1;
				src_stages <= DATA_W'(tex_rd.stg);
				src_access <= DATA_W'(tex_rd.acc);
			end
			if (cmd_s1 == CMD_FINAL) begin
				dst_stages <= DATA_W'(final_dst_q);
				dst_access <= '0;
			end else begin
				dst_stages <= DATA_W'(stg_s1);
				dst_access <= DATA_W'(acc_s1);
			end
		end
	end

endmodule

`default_nettype wire
